// ===== hdl/brfb_pkg.sv =====
package brfb_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned COUNT_W = 9;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_READ  = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE_DONE   = 2'd0,
    KIND_READ_BYTE    = 2'd1,
    KIND_READ_REFUSED = 2'd2
  } kind_t;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic store;
    logic report;
    logic refuse;
    logic start;
    logic fetch;
    logic load_byte;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic bad_read;
    logic pend;
    logic pend_last;
    logic rem_nz;
    logic out_valid;
  } status_t;

endpackage

// ===== hdl/byte_ring_fifo_burst_unit.sv =====
// circular byte fifo with burst writes and burst reads
// input channel (in_valid/in_ready): action 0 stores data_in, one byte per
//   transfer; the byte is dropped when the fifo is full. burst_end on a write
//   yields one result (kind 0) with the bytes stored during that burst.
// action 1 asks for read_length bytes: with read_length in 1..MAX_READ and
//   enough bytes held they come out oldest first, kind 1, last on the final
//   one; otherwise one kind 2 result. output channel (out_valid/out_ready) is one output register.
// writes: one transfer per cycle while the output register is free; a burst-end
//   result appears in the cycle after the transfer. reads: a refusal result
//   appears in the cycle after the transfer; a served read fetches each byte
//   through the registered read port of the storage ram into the output
//   register, one byte per cycle while the receiver takes them. the next input
//   can be taken from the cycle after the last byte is loaded, once the output register frees.
// reset empties the fifo and clears the burst count; the storage itself is
//   not cleared and needs no clearing pass.
// when the receiver stalls, the output register holds its result, the byte
//   fetch stops and no new input is taken until the register frees.
module byte_ring_fifo_burst_unit #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic [brfb_pkg::DATA_W-1:0]  data_in,
  input  logic                         burst_end,
  input  logic [brfb_pkg::LEN_W-1:0]   read_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [brfb_pkg::DATA_W-1:0]  data_out,
  output logic [brfb_pkg::COUNT_W-1:0] accepted_count,
  output logic                         last
);

  import brfb_pkg::*;

  cmd_t    cmd;
  status_t status;

  brfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .burst_end(burst_end),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  brfb_dpath #(
    .DEPTH   (DEPTH),
    .MAX_READ(MAX_READ)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .data_in       (data_in),
    .read_length   (read_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .data_out      (data_out),
    .accepted_count(accepted_count),
    .last          (last)
  );

endmodule

// ===== hdl/brfb_ram.sv =====
module brfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/brfb_ctrl.sv =====
module brfb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic              burst_end,
  input  logic              out_ready,
  input  brfb_pkg::status_t status,
  output brfb_pkg::cmd_t    cmd
);

  import brfb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  assign out_free = !status.out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.store     = accept && (action == ACTION_WRITE) && !status.full;
    cmd.report    = accept && (action == ACTION_WRITE) && burst_end;
    cmd.refuse    = accept && (action == ACTION_READ) && status.bad_read;
    cmd.start     = accept && (action == ACTION_READ) && !status.bad_read;
    cmd.load_byte = (state == ST_READ) && status.pend && out_free;
    cmd.fetch     = (state == ST_READ) && status.rem_nz && (!status.pend || cmd.load_byte);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (cmd.load_byte && status.pend_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/brfb_dpath.sv =====
module brfb_dpath #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  brfb_pkg::cmd_t                  cmd,
  output brfb_pkg::status_t               status,
  input  logic [brfb_pkg::DATA_W-1:0]     data_in,
  input  logic [brfb_pkg::LEN_W-1:0]      read_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      kind,
  output logic [brfb_pkg::DATA_W-1:0]     data_out,
  output logic [brfb_pkg::COUNT_W-1:0]    accepted_count,
  output logic                            last
);

  import brfb_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (OW > LEN_W) ? OW : LEN_W;
  localparam int unsigned RW = $clog2(MAX_READ + 1);

  logic [PW-1:0]      wptr;
  logic [PW-1:0]      rptr;
  logic [OW-1:0]      occ;
  logic [COUNT_W-1:0] burst_cnt;
  logic [COUNT_W-1:0] burst_cnt_inc;
  logic [RW-1:0]      rem;
  logic               pend;
  logic               pend_last;
  logic [DATA_W-1:0]  ram_q;
  logic [CW-1:0]      len_ext;
  logic [CW-1:0]      occ_ext;
  logic               load;
  kind_t              kind_q;

  assign len_ext = CW'(read_length);
  assign occ_ext = CW'(occ);

  assign status.full      = (occ == OW'(DEPTH));
  assign status.bad_read  = (read_length == '0) || (len_ext > CW'(MAX_READ)) ||
                            (occ_ext < len_ext);
  assign status.pend      = pend;
  assign status.pend_last = pend_last;
  assign status.rem_nz    = (rem != '0);
  assign status.out_valid = out_valid;

  assign burst_cnt_inc = (cmd.store && burst_cnt != COUNT_MAX) ? burst_cnt + 1'b1 : burst_cnt;

  brfb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(wptr),
    .wdata(data_in),
    .re   (cmd.fetch),
    .raddr(rptr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      rptr      <= '0;
      occ       <= '0;
      burst_cnt <= '0;
      rem       <= '0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      if (cmd.store) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
        occ  <= occ + 1'b1;
      end
      if (cmd.start) begin
        occ <= occ - OW'(len_ext);
        rem <= RW'(read_length);
      end
      burst_cnt <= cmd.report ? '0 : burst_cnt_inc;
      if (cmd.fetch) begin
        rptr      <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
        rem       <= rem - 1'b1;
        pend      <= 1'b1;
        pend_last <= (rem == RW'(1));
      end else if (cmd.load_byte) begin
        pend <= 1'b0;
      end
    end
  end

  // output register
  assign load = cmd.report || cmd.refuse || cmd.load_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      kind_q         <= KIND_WRITE_DONE;
      data_out       <= '0;
      accepted_count <= burst_cnt_inc;
      last           <= 1'b1;
    end else if (cmd.refuse) begin
      kind_q         <= KIND_READ_REFUSED;
      data_out       <= '0;
      accepted_count <= '0;
      last           <= 1'b1;
    end else if (cmd.load_byte) begin
      kind_q         <= KIND_READ_BYTE;
      data_out       <= ram_q;
      accepted_count <= '0;
      last           <= pend_last;
    end
  end

  assign kind = kind_q;

endmodule

// ===== hdl/brfb_checker.sv =====
module brfb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   kind,
  input logic [brfb_pkg::DATA_W-1:0]  data_out,
  input logic [brfb_pkg::COUNT_W-1:0] accepted_count,
  input logic                         last
);

  import brfb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_out) &&
      $stable(accepted_count) && $stable(last))
    else $error("output transfer changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_READ_BYTE |-> last)
    else $error("burst report or refusal without last");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_READ_BYTE |-> data_out == '0)
    else $error("nonzero data on a non-byte result");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_WRITE_DONE |-> accepted_count == '0)
    else $error("nonzero count on a read result");

endmodule

bind byte_ring_fifo_burst_unit brfb_checker u_brfb_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .kind          (kind),
  .data_out      (data_out),
  .accepted_count(accepted_count),
  .last          (last)
);
